### sv/mp1d_pkg.sv
// ----------------------------------------------------------------------------
// mp1d_pkg: shared types and constants of the streaming 1-D max pool
// Field widths, config register codes, the window geometry bundle, the
// per-window slot record and the control bundle broadcast to the cell ring.
// ----------------------------------------------------------------------------
package mp1d_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int MAX_CHANNELS = 4;
  localparam int MAX_ROW      = 4096;

  localparam int COL_W = 12;  // column counter
  localparam int WIN_W = 13;  // window index, row length, window count
  localparam int CH_W  = 2;   // channel index
  localparam int WS_W  = 7;   // clamped window size (up to MAX_WINDOW)
  localparam int POS_W = 19;  // window start/end positions (plus padding)

  // config register numbers (byte address = 4 * number)
  typedef enum logic [2:0] {
    REG_IN_LEN      = 3'd0,
    REG_WINDOW_SIZE = 3'd1,
    REG_STRIDE      = 3'd2,
    REG_PAD_HEAD    = 3'd3,
    REG_OUT_LEN     = 3'd4,
    REG_CHANNELS    = 3'd5
  } mp_reg_t;

  // clamped geometry, ready for use
  typedef struct packed {
    logic [4:0]       st;
    logic [3:0]       pad;
    logic [WS_W-1:0]  ws;
    logic [WIN_W-1:0] nout;
    logic [WIN_W-1:0] len_m1;
    logic [CH_W-1:0]  chn_m1;
  } mp_geom_t;

  // running maxima of one open window, all channels
  typedef struct packed {
    logic [MAX_CHANNELS-1:0]                  seen;
    logic [MAX_CHANNELS-1:0][SAMPLE_BITS-1:0] maxv;
  } mp_slot_t;

  // control broadcast to every cell
  typedef struct packed {
    logic                   upd;
    logic [CH_W-1:0]        upd_ch;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   drain;
    logic [CH_W-1:0]        drain_ch;
    logic                   rotate;
    logic                   clr_all;
  } mp_cell_ctl_t;

endpackage

### sv/mp1d_cfg.sv
// ----------------------------------------------------------------------------
// mp1d_cfg: configuration registers
// APB-style register file for the pooling geometry, with the clamping of
// out-of-range values applied before the geometry reaches the datapath.
// ----------------------------------------------------------------------------
module mp1d_cfg import mp1d_pkg::*; #(
  parameter int MAX_WINDOW = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output mp_geom_t    geom
);

  logic [12:0] in_len_r, in_len_nxt;
  logic [4:0]  window_size_r, window_size_nxt;
  logic [4:0]  stride_r, stride_nxt;
  logic [3:0]  pad_head_r, pad_head_nxt;
  logic [12:0] out_len_r, out_len_nxt;
  logic [2:0]  channels_r, channels_nxt;
  logic        wr;

  assign wr = psel && penable && pwrite;

  always_comb begin
    in_len_nxt      = in_len_r;
    window_size_nxt = window_size_r;
    stride_nxt      = stride_r;
    pad_head_nxt    = pad_head_r;
    out_len_nxt     = out_len_r;
    channels_nxt    = channels_r;
    if (wr) begin
      unique case (paddr[4:2])
        REG_IN_LEN:      in_len_nxt      = pwdata[12:0];
        REG_WINDOW_SIZE: window_size_nxt = pwdata[4:0];
        REG_STRIDE:      stride_nxt      = pwdata[4:0];
        REG_PAD_HEAD:    pad_head_nxt    = pwdata[3:0];
        REG_OUT_LEN:     out_len_nxt     = pwdata[12:0];
        REG_CHANNELS:    channels_nxt    = pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_len_r      <= 13'd1;
      window_size_r <= 5'd2;
      stride_r      <= 5'd2;
      pad_head_r    <= 4'd0;
      out_len_r     <= 13'd1;
      channels_r    <= 3'd1;
    end else begin
      in_len_r      <= in_len_nxt;
      window_size_r <= window_size_nxt;
      stride_r      <= stride_nxt;
      pad_head_r    <= pad_head_nxt;
      out_len_r     <= out_len_nxt;
      channels_r    <= channels_nxt;
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_IN_LEN:      prdata = 32'(in_len_r);
      REG_WINDOW_SIZE: prdata = 32'(window_size_r);
      REG_STRIDE:      prdata = 32'(stride_r);
      REG_PAD_HEAD:    prdata = 32'(pad_head_r);
      REG_OUT_LEN:     prdata = 32'(out_len_r);
      REG_CHANNELS:    prdata = 32'(channels_r);
      default:         prdata = '0;
    endcase
  end

  // zero length, window size, stride or channel count reads as one; oversize saturates
  always_comb begin
    if (in_len_r == '0)
      geom.len_m1 = '0;
    else if (in_len_r > WIN_W'(MAX_ROW))
      geom.len_m1 = WIN_W'(MAX_ROW - 1);
    else
      geom.len_m1 = in_len_r - 13'd1;

    if (window_size_r == '0)
      geom.ws = WS_W'(1);
    else if (WS_W'(window_size_r) > WS_W'(MAX_WINDOW))
      geom.ws = WS_W'(MAX_WINDOW);
    else
      geom.ws = WS_W'(window_size_r);

    geom.st  = (stride_r == '0) ? 5'd1 : stride_r;
    geom.pad = pad_head_r;
    geom.nout = (out_len_r > WIN_W'(MAX_ROW)) ? WIN_W'(MAX_ROW) : out_len_r;

    if (channels_r == '0)
      geom.chn_m1 = '0;
    else if (channels_r >= 3'(MAX_CHANNELS))
      geom.chn_m1 = CH_W'(MAX_CHANNELS - 1);
    else
      geom.chn_m1 = CH_W'(channels_r - 3'd1);
  end

endmodule

### sv/mp1d_cell.sv
// ----------------------------------------------------------------------------
// mp1d_cell: one open-window cell of the ring
// Holds the running maxima of one window for every channel, decides from its
// window index whether the current column falls inside the window or closes
// it, and passes its contents to the previous cell when the ring rotates.
// ----------------------------------------------------------------------------
module mp1d_cell import mp1d_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  mp_geom_t           geom,
  input  logic [COL_W-1:0]   col,
  input  logic               last_col,
  input  logic [WIN_W-1:0]   idx,
  input  logic               head,
  input  mp_cell_ctl_t       ctl,
  input  mp_slot_t           nbr_in,
  output mp_slot_t           slot_q,
  output mp_slot_t           slot_fwd,
  output logic               closes
);

  logic [MAX_CHANNELS-1:0]                  seen_r, seen_nxt;
  logic [MAX_CHANNELS-1:0][SAMPLE_BITS-1:0] maxv_r, maxv_nxt;
  mp_slot_t                                 cur;
  logic [POS_W-1:0]                         start, stop, colpad;
  logic                                     live, hit;

  // positions shifted by pad so everything stays unsigned
  assign start  = POS_W'(idx) * POS_W'(geom.st);
  assign stop   = start + POS_W'(geom.ws);
  assign colpad = POS_W'(col) + POS_W'(geom.pad);
  assign live   = idx < geom.nout;
  assign hit    = live && (start <= colpad) && (stop > colpad);
  assign closes = live && ((stop <= colpad + POS_W'(1)) || last_col);

  assign slot_q.seen = seen_r;
  assign slot_q.maxv = maxv_r;

  // head cell drops the channel being emitted
  always_comb begin
    cur = slot_q;
    if (head && ctl.drain)
      cur.seen[ctl.drain_ch] = 1'b0;
  end

  assign slot_fwd = cur;

  always_comb begin
    seen_nxt = cur.seen;
    maxv_nxt = cur.maxv;
    if (ctl.rotate) begin
      seen_nxt = nbr_in.seen;
      maxv_nxt = nbr_in.maxv;
    end else if (ctl.upd && hit) begin
      if (!cur.seen[ctl.upd_ch] ||
          ($signed(ctl.sample) > $signed(cur.maxv[ctl.upd_ch]))) begin
        maxv_nxt[ctl.upd_ch] = ctl.sample;
        seen_nxt[ctl.upd_ch] = 1'b1;
      end
    end
    if (ctl.clr_all)
      seen_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else begin
      seen_r <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    maxv_r <= maxv_nxt;
  end

endmodule

### sv/max_pool_1d_stream_top.sv
// ----------------------------------------------------------------------------
// max_pool_1d_stream_top: streaming 1-D max pooling
// Samples of a row (column-major, channels interleaved) update a ring of
// window cells; closed windows are emitted window-major, channel-minor.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake           payload
//   in_*      input      in_valid/in_ready   in_sample
//   out_*     output     out_valid/out_ready out_pooled, out_window_index,
//                                            out_channel_index, out_last
//   cfg       input      psel/penable/pwrite paddr, pwdata, prdata (pready=1)
//
// A sample that closes no window is taken at once; samples stream back to back.
// A sample that closes windows holds in_ready low while its results
// (windows closed x channels, at most MAX_WINDOW x 4) are drained from the
// head cell into the output register; out_ready low stretches that run.
// The next sample is taken as soon as the last result of a run sits in the
// output register. rst_n is synchronous; after reset all windows are empty.
//
module max_pool_1d_stream_top import mp1d_pkg::*; #(
  parameter int MAX_WINDOW = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input transactions
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  // result transactions
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_pooled,
  output logic [COL_W-1:0]              out_window_index,
  output logic [CH_W-1:0]               out_channel_index,
  output logic                          out_last,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [4:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  // cell after the head; with a single cell the run limit stops at one window
  localparam int NXT   = (MAX_WINDOW > 1) ? 1 : 0;
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);

  mp_geom_t geom;

  mp1d_cfg #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .geom    (geom)
  );

  assign pready = 1'b1;

  // --------------------------------------------------------------------------
  // row position and emission run state
  // --------------------------------------------------------------------------
  logic                   busy_r, busy_nxt;      // draining closed windows
  logic [COL_W-1:0]       col_r, col_nxt;        // current column
  logic [CH_W-1:0]        chc_r, chc_nxt;        // current channel
  logic [WIN_W-1:0]       nw_r, nw_nxt;          // oldest window not emitted
  logic [CH_W-1:0]        ech_r, ech_nxt;        // channel being emitted
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;        // windows emitted this run

  logic                   out_valid_r, out_valid_nxt;
  logic [SAMPLE_BITS-1:0] out_pooled_r, out_pooled_nxt;
  logic [COL_W-1:0]       out_win_r, out_win_nxt;
  logic [CH_W-1:0]        out_ch_r, out_ch_nxt;
  logic                   out_last_r, out_last_nxt;

  logic                   last_col, last_ch, accept, push;
  logic                   win_done, more, emit_last, step_end;
  logic [CH_W-1:0]        upd_ch;
  mp_cell_ctl_t           ctl;

  mp_slot_t               slot_q   [MAX_WINDOW];
  mp_slot_t               slot_fwd [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]  closes;

  // --------------------------------------------------------------------------
  // cell ring: cell k tracks window nw_r + k; a rotation retires the head
  // window and the head's slot comes back at the tail for window nw_r + N
  // (channels above the active count keep their contents, as they should)
  // --------------------------------------------------------------------------
  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
    mp1d_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .geom     (geom),
      .col      (col_r),
      .last_col (last_col),
      .idx      (nw_r + WIN_W'(k)),
      .head     (k == 0),
      .ctl      (ctl),
      .nbr_in   (slot_fwd[(k + 1) % MAX_WINDOW]),
      .slot_q   (slot_q[k]),
      .slot_fwd (slot_fwd[k]),
      .closes   (closes[k])
    );
  end

  assign last_col = {1'b0, col_r} >= geom.len_m1;
  assign last_ch  = chc_r >= geom.chn_m1;
  assign upd_ch   = (chc_r > geom.chn_m1) ? geom.chn_m1 : chc_r;

  assign in_ready = !busy_r;
  assign accept   = in_valid && !busy_r;
  // one result per cycle into the output register when it is free or leaving
  assign push     = busy_r && (!out_valid_r || out_ready);

  // run ends after the last channel of a window when the next one stays open
  // or the per-step window limit is reached
  assign win_done  = ech_r == geom.chn_m1;
  assign more      = closes[NXT] && ((cnt_r + CNT_W'(1)) < CNT_W'(MAX_WINDOW));
  assign emit_last = win_done && !more;
  assign step_end  = (accept && last_ch && !closes[0]) || (push && emit_last);

  always_comb begin
    busy_nxt = busy_r;
    col_nxt  = col_r;
    chc_nxt  = chc_r;
    nw_nxt   = nw_r;
    ech_nxt  = ech_r;
    cnt_nxt  = cnt_r;

    ctl          = '0;
    ctl.upd_ch   = upd_ch;
    ctl.sample   = in_sample;
    ctl.drain_ch = ech_r;

    if (accept) begin
      ctl.upd = 1'b1;
      if (last_ch) begin
        if (closes[0]) begin
          busy_nxt = 1'b1;
          ech_nxt  = '0;
          cnt_nxt  = '0;
        end
      end else begin
        chc_nxt = chc_r + 2'd1;
      end
    end

    if (push) begin
      ctl.drain  = 1'b1;
      ctl.rotate = win_done;
      if (win_done) begin
        nw_nxt  = nw_r + 13'd1;
        ech_nxt = '0;
        cnt_nxt = cnt_r + CNT_W'(1);
      end else begin
        ech_nxt = ech_r + 2'd1;
      end
    end

    // end of the sample's work: next column, or restart the row
    if (step_end) begin
      busy_nxt = 1'b0;
      chc_nxt  = '0;
      if (last_col) begin
        col_nxt     = '0;
        nw_nxt      = '0;
        ctl.clr_all = 1'b1;
      end else begin
        col_nxt = col_r + 12'd1;
      end
    end
  end

  // output register
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_pooled_nxt = out_pooled_r;
    out_win_nxt    = out_win_r;
    out_ch_nxt     = out_ch_r;
    out_last_nxt   = out_last_r;
    if (push) begin
      out_valid_nxt  = 1'b1;
      out_pooled_nxt = slot_q[0].seen[ech_r] ? slot_q[0].maxv[ech_r] : '0;
      out_win_nxt    = nw_r[COL_W-1:0];
      out_ch_nxt     = ech_r;
      out_last_nxt   = emit_last;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      col_r       <= '0;
      chc_r       <= '0;
      nw_r        <= '0;
      ech_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      col_r       <= col_nxt;
      chc_r       <= chc_nxt;
      nw_r        <= nw_nxt;
      ech_r       <= ech_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_pooled_r <= out_pooled_nxt;
    out_win_r    <= out_win_nxt;
    out_ch_r     <= out_ch_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_pooled        = $signed(out_pooled_r);
  assign out_window_index  = out_win_r;
  assign out_channel_index = out_ch_r;
  assign out_last          = out_last_r;

`ifndef SYNTH
  // a run only ever drains windows that exist
  a_run_window_valid: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (nw_r < geom.nout))
    else $error("draining a window beyond out_len");

  // run stays within the window limit and the active channels
  a_run_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> ((cnt_r < CNT_W'(MAX_WINDOW)) && (ech_r <= geom.chn_m1)))
    else $error("emission run out of bounds");

  // the marked result closes the run and resets the channel count
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (push && emit_last) |=> (!busy_r && (chc_r == '0)))
    else $error("run continued past its last result");
`endif

endmodule

### tb/sv/max_pool_1d_stream_top_tb.sv
// ----------------------------------------------------------------------------
// max_pool_1d_stream_top_tb: self-checking bench for the streaming 1-D max pool
// Drives signed samples through the valid/ready input channel and programs
// the window geometry over the APB-style port. A software pool tracks the
// open windows and predicts the results not typed into the table; all are
// checked field by field against the result channel. A short table of directed
// transactions comes first, then random rows under random register settings.
// The sender idles in bursts and the receiver stalls on patterns.
// ----------------------------------------------------------------------------
module max_pool_1d_stream_top_tb import mp1d_pkg::*;;

  localparam int MAX_WIN        = 16;   // tracked windows, matches uut parameter
  localparam int SLOTS          = MAX_WIN * MAX_CHANNELS;
  localparam int IDLE_CYCLES    = 4;    // settle time once the result queue is empty
  localparam int WATCHDOG_LIMIT = 2000; // cycles with no transaction at all
  localparam int RANDOM_ITEMS   = 393;  // plus the directed samples, 415 in all
  localparam int DIR_ROWS       = 36;

  // one result transaction
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] pooled;
    logic [COL_W-1:0]              win;
    logic [CH_W-1:0]               chan;
    logic                          last;
  } pool_res_t;

  typedef enum logic {ROW_WR, ROW_SMP} row_kind_t;

  // directed row: a register write or a sample, optionally with its result
  typedef struct packed {
    row_kind_t kind;
    mp_reg_t   reg_id;
    logic [31:0] value;
    logic      typed;
    pool_res_t want;
  } dir_row_t;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  always #6 clk = ~clk;

  // uut inputs, all known from time zero
  logic                          in_valid  = 1'b0;
  logic signed [SAMPLE_BITS-1:0] in_sample = '0;
  logic                          out_ready = 1'b0;
  logic                          psel      = 1'b0;
  logic                          penable   = 1'b0;
  logic                          pwrite    = 1'b0;
  logic [4:0]                    paddr     = '0;
  logic [31:0]                   pwdata    = '0;

  // uut outputs
  logic                          in_ready;
  logic                          out_valid;
  logic signed [SAMPLE_BITS-1:0] out_pooled;
  logic [COL_W-1:0]              out_window_index;
  logic [CH_W-1:0]               out_channel_index;
  logic                          out_last;
  logic [31:0]                   prdata;
  logic                          pready;

  // sideband that travels with each input transaction: a typed-in result
  logic      in_typed     = 1'b0;
  pool_res_t in_typed_res = '0;

  max_pool_1d_stream_top #(.MAX_WINDOW(MAX_WIN)) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample         (in_sample),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pooled        (out_pooled),
    .out_window_index  (out_window_index),
    .out_channel_index (out_channel_index),
    .out_last          (out_last),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // --------------------------------------------------------------------------
  // Software pool: register copies (reset values) and open-window state
  // --------------------------------------------------------------------------
  logic [12:0] in_len_r  = 13'd1;
  logic [4:0]  win_r     = 5'd2;
  logic [4:0]  stride_r  = 5'd2;
  logic [3:0]  pad_r     = 4'd0;
  logic [12:0] out_len_r = 13'd1;
  logic [2:0]  chan_r    = 3'd1;

  logic signed [SAMPLE_BITS-1:0] run_max [SLOTS];
  logic                          run_seen[SLOTS];
  logic [11:0]                   col_cnt  = '0;
  logic [1:0]                    chan_cnt = '0;
  int                            next_win = 0;

  pool_res_t closed_now[$];   // results caused by the latest sample
  pool_res_t pooled_due[$];   // results still owed by the uut
  int        mismatches = 0;

  initial begin
    foreach (run_max[j]) begin
      run_max[j]  = '0;
      run_seen[j] = 1'b0;
    end
  end

  // Fold one sample into the open windows; after the last channel, close the
  // windows that end on this column, or all on the last column, up to MAX_WIN.
  function automatic void pool_sample(input logic signed [SAMPLE_BITS-1:0] x);
    int len, ws, st, pad, nout, chn, ch, col, wi, s, e, slot, k, c;
    bit last_col, last_ch;
    pool_res_t r;
    len  = int'(in_len_r);
    len  = (len == 0) ? 1 : ((len > MAX_ROW) ? MAX_ROW : len);
    ws   = int'(win_r);
    ws   = (ws == 0) ? 1 : ((ws > MAX_WIN) ? MAX_WIN : ws);
    st   = (stride_r == 5'd0) ? 1 : int'(stride_r);
    pad  = int'(pad_r);
    nout = int'(out_len_r);
    nout = (nout > MAX_ROW) ? MAX_ROW : nout;
    chn  = int'(chan_r);
    chn  = (chn == 0) ? 1 : ((chn > MAX_CHANNELS) ? MAX_CHANNELS : chn);
    // a count past a freshly lowered limit acts as the last one
    ch       = (int'(chan_cnt) < chn) ? int'(chan_cnt) : chn - 1;
    col      = int'(col_cnt);
    last_col = col >= len - 1;
    last_ch  = int'(chan_cnt) >= chn - 1;
    closed_now.delete();

    // update every tracked window that covers this column
    for (k = 0; k < MAX_WIN; k++) begin
      wi = next_win + k;
      if (wi >= nout) break;
      s = wi * st - pad;
      e = s + ws;
      if (s > col) break;
      if (e > col) begin
        slot = (wi % MAX_WIN) * MAX_CHANNELS + ch;
        if (!run_seen[slot] || run_max[slot] < x) begin
          run_max[slot]  = x;
          run_seen[slot] = 1'b1;
        end
      end
    end

    if (last_ch) begin
      // close windows, oldest first, at most MAX_WIN of them
      for (k = 0; k < MAX_WIN; k++) begin
        wi = next_win;
        if (wi >= nout) break;
        e = wi * st - pad + ws;
        if (!(e <= col + 1 || last_col)) break;
        for (c = 0; c < chn; c++) begin
          slot     = (wi % MAX_WIN) * MAX_CHANNELS + c;
          r.pooled = run_seen[slot] ? run_max[slot] : '0;  // empty window gives 0
          r.win    = 12'(wi);
          r.chan   = 2'(c);
          r.last   = 1'b0;
          run_seen[slot] = 1'b0;
          run_max[slot]  = '0;
          closed_now.push_back(r);
        end
        next_win++;
      end
      if (closed_now.size() > 0) closed_now[closed_now.size()-1].last = 1'b1;
      chan_cnt = '0;
      if (last_col) begin
        col_cnt  = '0;
        next_win = 0;
        foreach (run_max[j]) begin
          run_max[j]  = '0;
          run_seen[j] = 1'b0;
        end
      end else begin
        col_cnt = col_cnt + 12'd1;
      end
    end else begin
      chan_cnt = chan_cnt + 2'd1;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Monitor and scoreboard: both channels sampled at the rising edge
  // --------------------------------------------------------------------------
  pool_res_t got, want;

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      pool_sample(in_sample);
      if (in_typed) pooled_due.push_back(in_typed_res);
      else foreach (closed_now[j]) pooled_due.push_back(closed_now[j]);
    end
    if (rst_n && out_valid && out_ready) begin
      got = '{out_pooled, out_window_index, out_channel_index, out_last};
      if (pooled_due.size() == 0) begin
        $display("%0t: unexpected result: expected none, %s pooled=%0d win=%0d ch=%0d last=%0d",
                 $time, "actual", $signed(got.pooled), got.win, got.chan, got.last);
        mismatches++;
      end else begin
        want = pooled_due.pop_front();
        if (got !== want) begin
          $display("%0t: result mismatch: expected pooled=%0d win=%0d ch=%0d last=%0d,",
                   $time, $signed(want.pooled), want.win, want.chan, want.last);
          $display("%0t:   actual pooled=%0d win=%0d ch=%0d last=%0d",
                   $time, $signed(got.pooled), got.win, got.chan, got.last);
          mismatches++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: ready pattern picked at random from four modes
  //   0 always ready, 1 random stalls, 2 five of eight, 3 one of sixteen
  // --------------------------------------------------------------------------
  logic [31:0] beat    = '0;
  logic [1:0]  rx_mode = 2'd0;

  always @(posedge clk) begin
    beat <= beat + 32'd1;
    if (beat[6:0] == 7'd0) rx_mode <= 2'($urandom_range(0, 3));
    case (rx_mode)
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= ($urandom_range(0, 2) != 0);
      2'd2: out_ready <= (beat[2:0] < 3'd5);
      default: out_ready <= (beat[3:0] == 4'd0);
    endcase
  end

  // --------------------------------------------------------------------------
  // Watchdog: any transaction on any port restarts the count
  // --------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sender helpers; all called right after a rising edge
  // --------------------------------------------------------------------------
  int burst_left = 0;
  bit steady     = 1'b0;  // phase without sender gaps

  function automatic int next_gap();
    if (steady || burst_left > 0) begin
      if (burst_left > 0) burst_left--;
      return 0;
    end
    burst_left = $urandom_range(1, 24);
    return $urandom_range(1, 5);
  endfunction

  task automatic send_sample(input logic [15:0] v, input logic typed, input pool_res_t res);
    int gap;
    in_valid     <= 1'b1;
    in_sample    <= v;
    in_typed     <= typed;
    in_typed_res <= res;
    do @(posedge clk); while (!in_ready);
    gap = next_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off until every owed result has come, then let the pipe settle
  task automatic wait_idle();
    if (in_valid) in_valid <= 1'b0;
    do @(posedge clk); while (pooled_due.size() != 0);
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  // setup cycle, access cycle, register taken at the access edge
  task automatic cfg_write(input mp_reg_t r, input logic [31:0] v);
    psel   <= 1'b1;
    pwrite <= 1'b1;
    paddr  <= {r, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (r)
      REG_IN_LEN:      in_len_r  = v[12:0];
      REG_WINDOW_SIZE: win_r     = v[4:0];
      REG_STRIDE:      stride_r  = v[4:0];
      REG_PAD_HEAD:    pad_r     = v[3:0];
      REG_OUT_LEN:     out_len_r = v[12:0];
      REG_CHANNELS:    chan_r    = v[2:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 3))
      0, 1: return 16'($urandom);
      2: return 16'($urandom_range(0, 8) - 4);   // narrow range, many ties
      default: begin
        case ($urandom_range(0, 3))
          0: return 16'h7FFF;
          1: return 16'h8000;
          2: return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Directed table. Results are typed in only after reset and for the
  // zero-register and all-padding cases; the rest go through the software
  // pool.
  // --------------------------------------------------------------------------
  dir_row_t dir_tab [DIR_ROWS] = '{
    // reset geometry: one column, one window, result equals the sample
    '{ROW_SMP, REG_IN_LEN,      32'h7FFF, 1'b1, '{16'sh7FFF, 12'd0, 2'd0, 1'b1}},
    '{ROW_SMP, REG_IN_LEN,      32'h8000, 1'b1, '{16'sh8000, 12'd0, 2'd0, 1'b1}},
    '{ROW_SMP, REG_IN_LEN,      32'h5555, 1'b1, '{16'sh5555, 12'd0, 2'd0, 1'b1}},
    '{ROW_SMP, REG_IN_LEN,      32'hAAAA, 1'b1, '{16'shAAAA, 12'd0, 2'd0, 1'b1}},
    '{ROW_SMP, REG_IN_LEN,      32'hFFFF, 1'b1, '{16'shFFFF, 12'd0, 2'd0, 1'b1}},
    // zero registers read as one
    '{ROW_WR,  REG_IN_LEN,      32'd0,    1'b0, '0},
    '{ROW_WR,  REG_WINDOW_SIZE, 32'd0,    1'b0, '0},
    '{ROW_WR,  REG_STRIDE,      32'd0,    1'b0, '0},
    '{ROW_WR,  REG_CHANNELS,    32'd0,    1'b0, '0},
    '{ROW_SMP, REG_IN_LEN,      32'd1234, 1'b1, '{16'sd1234, 12'd0, 2'd0, 1'b1}},
    // window entirely in padding
    '{ROW_WR,  REG_PAD_HEAD,    32'd15,   1'b0, '0},
    '{ROW_SMP, REG_IN_LEN,      32'd777,  1'b1, '{16'sd0, 12'd0, 2'd0, 1'b1}},
    // no windows at all
    '{ROW_WR,  REG_OUT_LEN,     32'd0,    1'b0, '0},
    '{ROW_SMP, REG_IN_LEN,      32'd100,  1'b0, '0},
    // oversize registers, long row, four channels
    '{ROW_WR,  REG_PAD_HEAD,    32'd3,    1'b0, '0},
    '{ROW_WR,  REG_WINDOW_SIZE, 32'd31,   1'b0, '0},
    '{ROW_WR,  REG_STRIDE,      32'd1,    1'b0, '0},
    '{ROW_WR,  REG_CHANNELS,    32'd7,    1'b0, '0},
    '{ROW_WR,  REG_OUT_LEN,     32'd8191, 1'b0, '0},
    '{ROW_WR,  REG_IN_LEN,      32'd8191, 1'b0, '0},
    '{ROW_SMP, REG_IN_LEN,      32'hFFFB, 1'b0, '0},
    '{ROW_SMP, REG_IN_LEN,      32'd300,  1'b0, '0},
    '{ROW_SMP, REG_IN_LEN,      32'h8000, 1'b0, '0},
    '{ROW_SMP, REG_IN_LEN,      32'h7FFF, 1'b0, '0},
    '{ROW_SMP, REG_IN_LEN,      32'd7,    1'b0, '0},
    '{ROW_SMP, REG_IN_LEN,      32'hFFF9, 1'b0, '0},
    '{ROW_SMP, REG_IN_LEN,      32'd0,    1'b0, '0},
    '{ROW_SMP, REG_IN_LEN,      32'd12,   1'b0, '0},
    // shorten the row mid-way: next column is the last, all 16 windows x 4
    // channels close at once and later windows are dropped
    '{ROW_WR,  REG_IN_LEN,      32'd3,    1'b0, '0},
    '{ROW_SMP, REG_IN_LEN,      32'd9,    1'b0, '0},
    '{ROW_SMP, REG_IN_LEN,      32'hFF9C, 1'b0, '0},
    '{ROW_SMP, REG_IN_LEN,      32'd20000,1'b0, '0},
    '{ROW_SMP, REG_IN_LEN,      32'hFFFF, 1'b0, '0},
    // fewer channels mid-column: current channel becomes the last one
    '{ROW_SMP, REG_IN_LEN,      32'd55,   1'b0, '0},
    '{ROW_WR,  REG_CHANNELS,    32'd1,    1'b0, '0},
    '{ROW_SMP, REG_IN_LEN,      32'd66,   1'b0, '0}
  };

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int sent, n, pick, len_v, ws_v, st_v, pad_v, out_v, chn_v;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_WR) begin
        wait_idle();
        cfg_write(dir_tab[i].reg_id, dir_tab[i].value);
      end else begin
        send_sample(dir_tab[i].value[15:0], dir_tab[i].typed, dir_tab[i].want);
      end
    end

    // random phases: new geometry (block idle), then mostly whole rows;
    // a row left open carries over into the next geometry
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick  = $urandom_range(0, 9);
      len_v = (pick < 7) ? $urandom_range(1, 12) : (pick == 7) ? 0 :
              (pick == 8) ? 8191 : $urandom_range(13, 8191);
      pick  = $urandom_range(0, 9);
      out_v = (pick < 6) ? $urandom_range(1, 16) : (pick == 6) ? 0 :
              (pick == 7) ? 8191 : $urandom_range(0, 8191);
      ws_v  = $urandom_range(0, 31);
      st_v  = ($urandom_range(0, 3) == 0) ? 31 * $urandom_range(0, 1) : $urandom_range(0, 31);
      pad_v = ($urandom_range(0, 3) == 0) ? 15 * $urandom_range(0, 1) : $urandom_range(0, 15);
      chn_v = $urandom_range(0, 7);

      wait_idle();
      cfg_write(REG_IN_LEN,      32'(len_v));
      cfg_write(REG_WINDOW_SIZE, 32'(ws_v));
      cfg_write(REG_STRIDE,      32'(st_v));
      cfg_write(REG_PAD_HEAD,    32'(pad_v));
      cfg_write(REG_OUT_LEN,     32'(out_v));
      cfg_write(REG_CHANNELS,    32'(chn_v));

      // whole rows for short rows, a slice of a long row otherwise
      if (len_v > 12) n = $urandom_range(20, 60);
      else n = $urandom_range(1, 3) * ((len_v == 0) ? 1 : len_v) *
               ((chn_v == 0) ? 1 : ((chn_v > MAX_CHANNELS) ? MAX_CHANNELS : chn_v));
      if (n > 60) n = $urandom_range(20, 60);
      if ($urandom_range(0, 6) == 0) n = $urandom_range(1, 9);  // broken row
      if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
      steady = ($urandom_range(0, 3) == 0);

      repeat (n) begin
        send_sample(rand_sample(), 1'b0, '0);
        sent++;
        // sender holds back until the uut has caught up
        if ($urandom_range(0, 39) == 0) wait_idle();
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### max_pool_1d_stream_top.f
sv/mp1d_pkg.sv
sv/mp1d_cfg.sv
sv/mp1d_cell.sv
sv/max_pool_1d_stream_top.sv
tb/sv/max_pool_1d_stream_top_tb.sv
